// ===== src/arbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Audio ring buffer package
// Shared word types, register indexes and reset values of the ring buffer.
// ----------------------------------------------------------------------------
package arbf_pkg;

	localparam int unsigned MAX_PACKET = 1024;

	localparam logic [1:0] OP_WRITE    = 2'd0;
	localparam logic [1:0] OP_READ     = 2'd1;
	localparam logic [1:0] OP_FEEDBACK = 2'd2;

	localparam logic [1:0] REG_BLOCK_BYTES = 2'd0;
	localparam logic [1:0] REG_RING_SIZE   = 2'd1;
	localparam logic [1:0] REG_NOMINAL_FB  = 2'd2;
	localparam logic [1:0] REG_ADJUST_STEP = 2'd3;

	localparam logic [10:0] RST_BLOCK_BYTES = 11'd200;
	localparam logic [12:0] RST_RING_SIZE   = 13'd4000;
	localparam logic [23:0] RST_NOMINAL_FB  = 24'd786432;
	localparam logic [6:0]  RST_ADJUST_STEP = 7'd100;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  data_in;
		logic        first;
		logic [10:0] packet_len;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  data_out;
		logic        underrun;
		logic        dropped;
		logic        playing;
		logic [23:0] rate_fb;
		logic [12:0] fill_level;
	} out_word_t;

	typedef struct packed {
		logic        is_write;
		logic        is_read;
		logic        is_fb;
		logic [7:0]  data;
		logic        first;
		logic [10:0] len;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

// ===== src/audio_ring_buffer_feedback_core.sv =====
// ----------------------------------------------------------------------------
// Audio ring buffer with rate feedback
// Byte ring between an audio packet source and a playback sink, with a rate
// feedback word for the source.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while it does not stall the input,
// and returns one result word per input word, in order. A word accepted into
// the queue is carried out when the back end loads its result into the output
// register, which it does whenever the output register is empty or being taken.
// A two-entry queue after the input decode lets the input keep flowing while
// the output is stalled, until both entries are full. The ring memory takes
// one byte write and one byte read per loaded word, so each word is done whole.
// Configuration writes must be made while no word is in flight; writing the
// ring size restarts the buffer.
module audio_ring_buffer_feedback_core #(
	parameter int unsigned RING_DEPTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  arbf_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output arbf_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data
);
	import arbf_pkg::*;

	queue_head_t head;
	logic        pop;

	arbf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.head     (head),
		.pop      (pop)
	);

	arbf_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// ===== src/arbf_front.sv =====
// ----------------------------------------------------------------------------
// Audio ring buffer front end
// Accepts input words, decodes the opcode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module arbf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  arbf_pkg::in_word_t in_word,
	output arbf_pkg::queue_head_t head,
	input  logic              pop
);
	import arbf_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	item_t      decoded;

	always_comb begin
		decoded          = '0;
		decoded.is_write = (in_word.opcode == OP_WRITE);
		decoded.is_read  = (in_word.opcode == OP_READ);
		decoded.is_fb    = (in_word.opcode == OP_FEEDBACK);
		decoded.data     = in_word.data_in;
		decoded.first    = in_word.first;
		decoded.len      = in_word.packet_len;
	end

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: begin
					count_q <= count_q + 2'd1;
				end
				2'b01: begin
					count_q <= count_q - 2'd1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

// ===== src/arbf_back.sv =====
// ----------------------------------------------------------------------------
// Audio ring buffer back end
// Executes decoded words against the ring memory and pointers, and holds the
// result word in an output register.
// ----------------------------------------------------------------------------
module arbf_back #(
	parameter int unsigned RING_DEPTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  arbf_pkg::queue_head_t head,
	output logic                  pop,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [23:0]           cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output arbf_pkg::out_word_t   out_word
);
	import arbf_pkg::*;

	localparam int unsigned PW = $clog2(RING_DEPTH);
	localparam int unsigned LW = PW + 1;

	logic [7:0]    mem [RING_DEPTH];

	logic [10:0]   block_bytes_q;
	logic [12:0]   ring_size_q;
	logic [23:0]   nominal_fb_q;
	logic [6:0]    adjust_step_q;

	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic          started_q;
	logic [LW-1:0] snap_q;
	logic [7:0]    adj_q;
	logic          wacc_q;
	logic [10:0]   wrem_q;
	logic          granted_q;

	out_word_t     res_s2;
	logic          hit_s2;
	logic [7:0]    rd_data_s2;
	logic          valid_s2;

	logic [LW-1:0] rlen;
	logic [LW-1:0] half;
	logic [LW-1:0] quarter;
	logic [LW+1:0] three_r;
	logic [LW-1:0] three_q;
	logic [LW-1:0] fill_cur;
	logic [LW-1:0] fill_after;
	logic [LW-1:0] space;
	logic          load;
	item_t         it;

	logic [PW-1:0] wp_n;
	logic [PW-1:0] rp_n;
	logic          started_n;
	logic [LW-1:0] snap_n;
	logic [7:0]    adj_n;
	logic          wacc_n;
	logic [10:0]   wrem_n;
	logic          granted_n;
	logic          mem_we;
	logic          hit;
	out_word_t     res;

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
			input logic [LW-1:0] r);
		logic [LW-1:0] n;
		n = {1'b0, p} + LW'(1);
		return (n >= r) ? '0 : n[PW-1:0];
	endfunction

	function automatic logic [LW-1:0] fill_of(input logic [PW-1:0] w,
			input logic [PW-1:0] rd, input logic [LW-1:0] r);
		if (w >= rd) begin
			return {1'b0, w} - {1'b0, rd};
		end
		return r - {1'b0, rd} + {1'b0, w};
	endfunction

	always_comb begin
		if (ring_size_q < 13'd2) begin
			rlen = LW'(2);
		end else if (32'(ring_size_q) > 32'(RING_DEPTH)) begin
			rlen = LW'(RING_DEPTH);
		end else begin
			rlen = LW'(ring_size_q);
		end
	end

	assign half     = rlen >> 1;
	assign quarter  = rlen >> 2;
	assign three_r  = {2'b00, rlen} + {1'b0, rlen, 1'b0};
	assign three_q  = three_r[LW+1:2];
	assign fill_cur = fill_of(wp_q, rp_q, rlen);
	assign space    = rlen - fill_cur;
	assign it       = head.item;
	assign load     = head.valid && (!valid_s2 || !out_stall);
	assign pop      = load;

	always_comb begin
		wp_n      = wp_q;
		rp_n      = rp_q;
		started_n = started_q;
		snap_n    = snap_q;
		adj_n     = adj_q;
		wacc_n    = wacc_q;
		wrem_n    = wrem_q;
		granted_n = granted_q;
		mem_we    = 1'b0;
		hit       = 1'b0;
		res       = '0;
		if (it.is_write) begin
			if (it.first) begin
				wacc_n = (32'(it.len) <= 32'(MAX_PACKET)) && (32'(space) > 32'(it.len));
				wrem_n = wacc_n ? it.len : 11'd0;
			end
			if (wacc_n && (wrem_n != 11'd0)) begin
				mem_we = 1'b1;
				wp_n   = advance(wp_q, rlen);
				wrem_n = wrem_n - 11'd1;
			end
			res.dropped = !wacc_n;
			if ((wrem_n == 11'd0) && !started_q && ({1'b0, wp_n} >= half)) begin
				started_n = 1'b1;
			end
		end else if (it.is_read) begin
			if (!started_q) begin
				res.underrun = 1'b1;
			end else begin
				if (it.first) begin
					snap_n    = fill_cur;
					granted_n = 32'(fill_cur) > 32'(block_bytes_q);
				end
				if (granted_n && (fill_cur != '0)) begin
					hit  = 1'b1;
					rp_n = advance(rp_q, rlen);
				end else begin
					res.underrun = 1'b1;
				end
			end
		end else if (it.is_fb) begin
			if (snap_q > three_q) begin
				adj_n = 8'd0 - {1'b0, adjust_step_q};
			end else if (snap_q < quarter) begin
				adj_n = {1'b0, adjust_step_q};
			end
			res.rate_fb = nominal_fb_q + {{16{adj_n[7]}}, adj_n};
		end
		fill_after     = fill_of(wp_n, rp_n, rlen);
		res.playing    = started_n;
		res.fill_level = 13'(fill_after);
	end

	always_ff @(posedge clk) begin
		if (load && mem_we) begin
			mem[wp_q] <= it.data;
		end
		if (load) begin
			rd_data_s2 <= mem[rp_q];
			res_s2     <= res;
			hit_s2     <= hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= RST_BLOCK_BYTES;
			ring_size_q   <= RST_RING_SIZE;
			nominal_fb_q  <= RST_NOMINAL_FB;
			adjust_step_q <= RST_ADJUST_STEP;
			wp_q          <= '0;
			rp_q          <= '0;
			started_q     <= 1'b0;
			snap_q        <= '0;
			adj_q         <= 8'd0;
			wacc_q        <= 1'b0;
			wrem_q        <= 11'd0;
			granted_q     <= 1'b0;
			valid_s2      <= 1'b0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BLOCK_BYTES: begin
						block_bytes_q <= cfg_data[10:0];
					end
					REG_RING_SIZE: begin
						ring_size_q <= cfg_data[12:0];
						wp_q        <= '0;
						rp_q        <= '0;
						started_q   <= 1'b0;
						wacc_q      <= 1'b0;
						wrem_q      <= 11'd0;
						granted_q   <= 1'b0;
					end
					REG_NOMINAL_FB: begin
						nominal_fb_q <= cfg_data;
					end
					REG_ADJUST_STEP: begin
						adjust_step_q <= cfg_data[6:0];
					end
					default: begin
						block_bytes_q <= block_bytes_q;
					end
				endcase
			end else if (load) begin
				wp_q      <= wp_n;
				rp_q      <= rp_n;
				started_q <= started_n;
				snap_q    <= snap_n;
				adj_q     <= adj_n;
				wacc_q    <= wacc_n;
				wrem_q    <= wrem_n;
				granted_q <= granted_n;
			end
		end
	end

	always_comb begin
		out_word          = res_s2;
		out_word.data_out = hit_s2 ? rd_data_s2 : 8'd0;
	end

	assign out_valid = valid_s2;

endmodule

// ===== tb/arbf_ring_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Audio ring buffer checker
// Watches the input, result and register ports of the ring buffer, keeps its
// own copy of the ring, the pointers, the playback flag and the feedback
// adjustment, and compares every result word field by field with the word it
// predicted for the matching input word.
// ----------------------------------------------------------------------------
module arbf_ring_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  arbf_pkg::in_word_t  in_word,
	input  logic                out_valid,
	input  logic                out_stall,
	input  arbf_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	output int unsigned         mismatches,
	output int unsigned         pending
);
	import arbf_pkg::*;

	localparam int unsigned RING_DEPTH = 4096;

	logic [10:0] block_bytes;
	logic [12:0] ring_size;
	logic [23:0] nominal_fb;
	logic [6:0]  adjust_step;

	logic [7:0]  ring_mem [RING_DEPTH];
	int unsigned wr_ptr;
	int unsigned rd_ptr;
	int unsigned pkt_left;
	int unsigned fill_snap;
	logic [7:0]  adjust;
	logic        playing;
	logic        pkt_open;
	logic        block_granted;

	out_word_t   expected_words [$];
	int unsigned mismatch_count = 0;
	int unsigned word_count;

	assign mismatches = mismatch_count;

	function automatic int unsigned ring_len();
		if (ring_size < 2)
			return 2;
		if (ring_size > RING_DEPTH)
			return RING_DEPTH;
		return ring_size;
	endfunction

	function automatic int unsigned ring_fill();
		if (wr_ptr >= rd_ptr)
			return wr_ptr - rd_ptr;
		return ring_len() - rd_ptr + wr_ptr;
	endfunction

	function automatic int unsigned next_pos(int unsigned p);
		return (p + 1 >= ring_len()) ? 0 : p + 1;
	endfunction

	function automatic void restart_flow();
		wr_ptr = 0;
		rd_ptr = 0;
		playing = 1'b0;
		pkt_open = 1'b0;
		pkt_left = 0;
		block_granted = 1'b0;
	endfunction

	function automatic out_word_t ring_step_result(in_word_t w);
		out_word_t r;
		int unsigned room;
		r = '0;
		case (w.opcode)
		OP_WRITE: begin
			if (w.first) begin
				room = ring_len() - ring_fill();
				pkt_open = (w.packet_len <= MAX_PACKET) && (room > w.packet_len);
				pkt_left = pkt_open ? w.packet_len : 0;
			end
			if (pkt_open && pkt_left > 0) begin
				ring_mem[wr_ptr] = w.data_in;
				wr_ptr = next_pos(wr_ptr);
				pkt_left--;
			end
			r.dropped = !pkt_open;
			if (pkt_left == 0 && !playing && wr_ptr >= ring_len() / 2)
				playing = 1'b1;
		end
		OP_READ: begin
			if (!playing) begin
				r.underrun = 1'b1;
			end else begin
				if (w.first) begin
					fill_snap = ring_fill();
					block_granted = fill_snap > block_bytes;
				end
				if (block_granted && ring_fill() > 0) begin
					r.data_out = ring_mem[rd_ptr];
					rd_ptr = next_pos(rd_ptr);
				end else begin
					r.underrun = 1'b1;
				end
			end
		end
		OP_FEEDBACK: begin
			if (fill_snap > ring_len() * 3 / 4)
				adjust = 8'd0 - {1'b0, adjust_step};
			else if (fill_snap < ring_len() / 4)
				adjust = {1'b0, adjust_step};
			r.rate_fb = nominal_fb + {{16{adjust[7]}}, adjust};
		end
		default: ;
		endcase
		r.playing = playing;
		r.fill_level = 13'(ring_fill());
		return r;
	endfunction

	task automatic report(string msg);
		mismatch_count++;
		$display("%0t ns: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [23:0] got, logic [23:0] want);
		if (got !== want)
			report($sformatf("result word %0d: %s is %0h, expected %0h",
				word_count, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			block_bytes = RST_BLOCK_BYTES;
			ring_size = RST_RING_SIZE;
			nominal_fb = RST_NOMINAL_FB;
			adjust_step = RST_ADJUST_STEP;
			restart_flow();
			fill_snap = 0;
			adjust = '0;
			expected_words.delete();
			word_count = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report($sformatf("result word %0d arrived with nothing expected",
						word_count));
				end else begin
					want = expected_words.pop_front();
					check_field("data_out", 24'(out_word.data_out), 24'(want.data_out));
					check_field("underrun", 24'(out_word.underrun), 24'(want.underrun));
					check_field("dropped", 24'(out_word.dropped), 24'(want.dropped));
					check_field("playing", 24'(out_word.playing), 24'(want.playing));
					check_field("rate_fb", out_word.rate_fb, want.rate_fb);
					check_field("fill_level", 24'(out_word.fill_level),
						24'(want.fill_level));
				end
				word_count++;
			end
			if (in_valid && !in_stall)
				expected_words.push_back(ring_step_result(in_word));
			if (cfg_we) begin
				case (cfg_index)
				REG_BLOCK_BYTES: block_bytes = cfg_data[10:0];
				REG_RING_SIZE: begin
					ring_size = cfg_data[12:0];
					restart_flow();
				end
				REG_NOMINAL_FB: nominal_fb = cfg_data;
				REG_ADJUST_STEP: adjust_step = cfg_data[6:0];
				default: ;
				endcase
			end
			pending <= expected_words.size();
		end
	end

endmodule

// ===== tb/audio_ring_buffer_feedback_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Audio ring buffer testbench
// Drives write packets, playback blocks, feedback queries and stray words into
// the ring buffer under a series of register settings and handshake pressure
// modes, while a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module audio_ring_buffer_feedback_core_tb;
	import arbf_pkg::*;

	localparam logic [1:0] OP_IDLE = 2'd3;
	localparam int unsigned PHASES = 9;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_word_t    in_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_word;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_BLOCK_BYTES;
	logic [23:0] cfg_data = '0;
	int unsigned mismatches;
	int unsigned pending;

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned sent = 0;
	int unsigned len_cap;
	int unsigned read_len;

	audio_ring_buffer_feedback_core dut (
		.clk, .arst_n, .in_valid, .in_stall, .in_word,
		.out_valid, .out_stall, .out_word, .cfg_we, .cfg_index, .cfg_data
	);

	arbf_ring_checker ring_check (
		.clk, .arst_n, .in_valid, .in_stall, .in_word,
		.out_valid, .out_stall, .out_word, .cfg_we, .cfg_index, .cfg_data,
		.mismatches, .pending
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic in_word_t make_word(logic [1:0] op, logic [7:0] d, logic f,
		logic [10:0] len);
		in_word_t w;
		w.opcode = op;
		w.data_in = d;
		w.first = f;
		w.packet_len = len;
		return w;
	endfunction

	task automatic send(in_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic start_phase(int unsigned p);
		logic [10:0] bb;
		logic [12:0] rs;
		logic [23:0] nf;
		logic [6:0]  st;
		logic [31:0] rnd;
		case (p)
		0: begin bb = 8;    rs = 64;   nf = 24'hFFFFFF; st = 127; len_cap = 16; end
		1: begin bb = 0;    rs = 0;    nf = 24'h000000; st = 127; len_cap = 2;  end
		2: begin bb = 1024; rs = 8191; nf = 24'd12345;  st = 0;   len_cap = 40; end
		3: begin bb = 1;    rs = 2;    nf = 24'd786432; st = 1;   len_cap = 2;  end
		4: begin bb = 12;   rs = 100;  nf = 24'd786432; st = 100; len_cap = 24; end
		5: begin bb = 1;    rs = 4096; nf = 24'd5;      st = 64;  len_cap = 20; end
		6: begin bb = 5;    rs = 37;   nf = 24'hFFFF80; st = 127; len_cap = 10; end
		7: begin bb = 20;   rs = 200;  nf = 24'd600000; st = 33;  len_cap = 40; end
		default: begin bb = 2047; rs = 16; nf = 24'd1; st = 0; len_cap = 6; end
		endcase
		read_len = (bb == 11'd0) ? 1 : (bb > 11'd64) ? 64 : int'(bb);
		drain();
		rnd = $urandom;
		write_reg(REG_BLOCK_BYTES, {rnd[12:0], bb});
		write_reg(REG_RING_SIZE, {rnd[23:13], rs});
		write_reg(REG_NOMINAL_FB, nf);
		write_reg(REG_ADJUST_STEP, {rnd[31:15], st});
		cfg_we <= 1'b0;
		case (p % 4)
		0: begin idle_pct = 0;  stall_pct <= 0;  end
		1: begin idle_pct = 81; stall_pct <= 0;  end
		2: begin idle_pct = 0;  stall_pct <= 81; end
		default: begin idle_pct = 17; stall_pct <= 17; end
		endcase
	endtask

	task automatic random_traffic(int unsigned count);
		int unsigned stop;
		int unsigned kind;
		int unsigned len;
		int unsigned n;
		int unsigned i;
		logic [21:0] raw;
		stop = sent + count;
		while (sent < stop) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				len = $urandom_range(len_cap);
				n = len;
				if ($urandom_range(19) == 0) begin
					len = $urandom_range(2047, MAX_PACKET + 1);
					n = $urandom_range(len_cap);
				end
				case ($urandom_range(7))
				0: n = $urandom_range(n);
				1: n = n + $urandom_range(1, 3);
				default: ;
				endcase
				send(make_word(OP_WRITE, 8'($urandom), 1'b1, 11'(len)));
				for (i = 1; i < n; i++)
					send(make_word(OP_WRITE, 8'($urandom), 1'b0, 11'($urandom)));
			end else if (kind < 75) begin
				n = read_len;
				if ($urandom_range(7) == 0)
					n = $urandom_range(1, read_len + 2);
				send(make_word(OP_READ, 8'($urandom), 1'b1, 11'($urandom)));
				for (i = 1; i < n; i++)
					send(make_word(OP_READ, 8'($urandom), 1'b0, 11'($urandom)));
			end else if (kind < 85) begin
				send(make_word(OP_FEEDBACK, 8'($urandom), 1'($urandom),
					11'($urandom)));
			end else begin
				raw = 22'($urandom);
				send(raw);
			end
		end
	endtask

	initial begin
		int unsigned p;
		int unsigned i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: nothing plays yet, so reads give zeros.
		send(make_word(OP_READ, 8'hFF, 1'b1, 11'h7FF));
		send(make_word(OP_FEEDBACK, 8'h00, 1'b0, 11'd0));
		send(make_word(OP_WRITE, 8'hA5, 1'b1, 11'h7FF));
		send(make_word(OP_WRITE, 8'h5A, 1'b0, 11'd0));
		send(make_word(OP_WRITE, 8'h00, 1'b1, 11'(MAX_PACKET)));
		send(make_word(OP_WRITE, 8'hFF, 1'b0, 11'd0));
		send(make_word(OP_WRITE, 8'h12, 1'b1, 11'd0));
		send(make_word(OP_WRITE, 8'h34, 1'b0, 11'd0));
		send(make_word(OP_IDLE, 8'hFF, 1'b1, 11'h7FF));

		// A small ring so that playback starts after one packet.
		drain();
		write_reg(REG_RING_SIZE, 24'd16);
		write_reg(REG_BLOCK_BYTES, 24'd4);
		cfg_we <= 1'b0;
		send(make_word(OP_WRITE, 8'h80, 1'b1, 11'd8));
		for (i = 1; i < 8; i++)
			send(make_word(OP_WRITE, 8'(i * 37), 1'b0, 11'd0));
		send(make_word(OP_READ, 8'h00, 1'b0, 11'd0));
		send(make_word(OP_READ, 8'h00, 1'b1, 11'd0));
		send(make_word(OP_READ, 8'h00, 1'b0, 11'd0));
		send(make_word(OP_READ, 8'h00, 1'b0, 11'd0));
		send(make_word(OP_FEEDBACK, 8'h00, 1'b0, 11'd0));
		send(make_word(OP_WRITE, 8'h11, 1'b1, 11'd11));
		send(make_word(OP_WRITE, 8'h22, 1'b1, 11'd10));

		for (p = 0; p < PHASES; p++) begin
			start_phase(p);
			random_traffic(80);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
src/arbf_pkg.sv
src/arbf_front.sv
src/arbf_back.sv
src/audio_ring_buffer_feedback_core.sv
tb/arbf_ring_checker.sv
tb/audio_ring_buffer_feedback_core_tb.sv
